// File: rtl/core/klv_pkg.sv
// ----------------------------------------------------------------------------
// KLV essence element locator package
// Types and constants shared by the parser, the result buffer and the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package klv_pkg;

  localparam int KEY_BYTES = 16;

  // Generic-container essence element key prefix, padded to a full key.
  localparam logic [7:0] ESSENCE_PREFIX [KEY_BYTES] = '{
    8'h06, 8'h0e, 8'h2b, 8'h34, 8'h01, 8'h02, 8'h01, 8'hff,
    8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff
  };

  localparam logic STATUS_FOUND     = 1'b0;
  localparam logic STATUS_NOT_FOUND = 1'b1;

  typedef enum logic [4:0] {
    PH_KEY       = 5'b00001,
    PH_LEN_FIRST = 5'b00010,
    PH_LEN_MORE  = 5'b00100,
    PH_SKIP      = 5'b01000,
    PH_DONE      = 5'b10000
  } phase_t;

  typedef struct packed {
    logic        status;
    logic [63:0] value_offset;
    logic [63:0] value_length;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/core/klv_byte_if.sv
// ----------------------------------------------------------------------------
// KLV byte stream channel
// Valid/ready channel carrying one file byte and its start and end flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface klv_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output first_byte,
                  output last_byte, input ready);
  modport sink (input valid, input data_byte, input first_byte,
                input last_byte, output ready);
endinterface

`default_nettype wire

// File: rtl/core/klv_result_if.sv
// ----------------------------------------------------------------------------
// KLV locator result channel
// Valid/ready channel carrying the search status, value offset and length.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface klv_result_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [63:0] value_offset;
  logic [63:0] value_length;

  modport source (output valid, output status, output value_offset,
                  output value_length, input ready);
  modport sink (input valid, input status, input value_offset,
                input value_length, output ready);
endinterface

`default_nettype wire

// File: rtl/core/klv_parse.sv
// ----------------------------------------------------------------------------
// KLV triplet parser
// Walks key, BER length and value bytes one byte per transfer and raises a
// result when an essence element is found or the file ends without one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module klv_parse #(
  parameter int PREFIX_BYTES = 7
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   accept,
  input  wire  [7:0]            data_byte,
  input  wire                   first_byte,
  input  wire                   last_byte,
  output logic                  res_push,
  output klv_pkg::result_t      res
);
  import klv_pkg::*;

  localparam logic [4:0] PREFIX_LIMIT = 5'(PREFIX_BYTES);

  phase_t      phase, phase_next, ph_b;
  logic [3:0]  key_idx, key_idx_next, idx_b;
  logic        match, match_next, match_b;
  logic [6:0]  left, left_next, left_b;
  logic [63:0] acc, acc_next, acc_b;
  logic [63:0] skip, skip_next, skip_b;
  logic [63:0] pos, pos_next, pos_b;
  logic        len_complete;
  logic        res_valid;
  result_t     res_next;

  always_comb begin
    // A first byte restarts the parse before the byte itself is taken.
    ph_b    = first_byte ? PH_KEY : phase;
    idx_b   = first_byte ? 4'd0 : key_idx;
    match_b = first_byte | match;
    left_b  = first_byte ? 7'd0 : left;
    acc_b   = first_byte ? 64'd0 : acc;
    skip_b  = first_byte ? 64'd0 : skip;
    pos_b   = first_byte ? 64'd0 : pos;

    phase_next   = ph_b;
    key_idx_next = idx_b;
    match_next   = match_b;
    left_next    = left_b;
    acc_next     = acc_b;
    skip_next    = skip_b;
    pos_next     = pos_b;
    len_complete = 1'b0;
    res_valid    = 1'b0;
    res_next     = '0;

    if (ph_b != PH_DONE) begin
      pos_next = pos_b + 64'd1;
      case (ph_b)
        PH_KEY: begin
          if (({1'b0, idx_b} < PREFIX_LIMIT) && (data_byte != ESSENCE_PREFIX[idx_b])) begin
            match_next = 1'b0;
          end
          if (idx_b == 4'd15) begin
            key_idx_next = 4'd0;
            phase_next   = PH_LEN_FIRST;
          end else begin
            key_idx_next = idx_b + 4'd1;
          end
        end
        PH_LEN_FIRST: begin
          if (!data_byte[7]) begin
            acc_next     = {56'd0, data_byte};
            len_complete = 1'b1;
          end else begin
            acc_next  = 64'd0;
            left_next = data_byte[6:0];
            if (data_byte[6:0] == 7'd0) begin
              len_complete = 1'b1;
            end else begin
              phase_next = PH_LEN_MORE;
            end
          end
        end
        PH_LEN_MORE: begin
          acc_next  = {acc_b[55:0], data_byte};
          left_next = left_b - 7'd1;
          if (left_next == 7'd0) begin
            len_complete = 1'b1;
          end
        end
        PH_SKIP: begin
          skip_next = skip_b - 64'd1;
          if (skip_next == 64'd0) begin
            phase_next = PH_KEY;
          end
        end
        default: begin
          phase_next = PH_DONE;
        end
      endcase

      if (len_complete) begin
        if (match_b) begin
          res_valid             = 1'b1;
          res_next.status       = STATUS_FOUND;
          res_next.value_offset = pos_next;
          res_next.value_length = acc_next;
          phase_next            = PH_DONE;
        end else begin
          skip_next    = acc_next;
          phase_next   = (acc_next == 64'd0) ? PH_KEY : PH_SKIP;
          key_idx_next = 4'd0;
          match_next   = 1'b1;
        end
      end

      if (!res_valid && last_byte && (phase_next != PH_DONE)) begin
        res_valid       = 1'b1;
        res_next.status = STATUS_NOT_FOUND;
        phase_next      = PH_DONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_KEY;
      key_idx <= 4'd0;
      match   <= 1'b1;
      left    <= 7'd0;
      acc     <= 64'd0;
      skip    <= 64'd0;
      pos     <= 64'd0;
    end else if (accept) begin
      phase   <= phase_next;
      key_idx <= key_idx_next;
      match   <= match_next;
      left    <= left_next;
      acc     <= acc_next;
      skip    <= skip_next;
      pos     <= pos_next;
    end
  end

  assign res_push = accept & res_valid;
  assign res      = res_next;

`ifndef ASSERT_OFF
  a_done_after_result: assert property (@(posedge clk) disable iff (rst)
    res_push |=> (phase == PH_DONE))
    else $error("parser not done after giving a result");

  a_idx_zero_outside_key: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_LEN_FIRST || phase == PH_LEN_MORE || phase == PH_SKIP) |-> (key_idx == 4'd0))
    else $error("key byte index left nonzero outside the key");

  a_more_has_bytes: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_LEN_MORE) |-> (left != 7'd0))
    else $error("long-form length phase with no bytes left");

  a_skip_nonzero: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_SKIP) |-> (skip != 64'd0))
    else $error("skipping a value with nothing left to skip");
`endif

endmodule

`default_nettype wire

// File: rtl/core/klv_out_buf.sv
// ----------------------------------------------------------------------------
// KLV result buffer
// Output register with one skid entry, so the parser keeps taking bytes
// while a result waits on the result channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module klv_out_buf (
  input  wire              clk,
  input  wire              rst,
  input  wire              push,
  input  klv_pkg::result_t push_data,
  output logic             can_accept,
  klv_result_if.source     results
);
  import klv_pkg::*;

  logic    main_valid, skid_valid;
  result_t main_data, skid_data;
  logic    pop;

  assign pop        = main_valid & results.ready;
  assign can_accept = ~skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!main_valid || pop) begin
      main_valid <= skid_valid | push;
      skid_valid <= 1'b0;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!main_valid || pop) begin
      main_data <= skid_valid ? skid_data : push_data;
    end else if (push) begin
      skid_data <= push_data;
    end
  end

  assign results.valid        = main_valid;
  assign results.status       = main_data.status;
  assign results.value_offset = main_data.value_offset;
  assign results.value_length = main_data.value_length;

`ifndef ASSERT_OFF
  a_skid_implies_main: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> main_valid)
    else $error("skid entry held while the output register is empty");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !skid_valid)
    else $error("result pushed into a full buffer");

  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && pop) |=> (main_valid && !skid_valid))
    else $error("skid entry not moved to the output register");
`endif

endmodule

`default_nettype wire

// File: rtl/core/klv_essence_element_locator.sv
// ----------------------------------------------------------------------------
// KLV essence element locator
// Parses a file as KLV triplets and reports the offset and BER length of the
// first generic-container essence element value, or that none was found.
// ----------------------------------------------------------------------------
//   channel   modport  payload                                   per transfer
//   bytes     sink     data_byte, first_byte, last_byte          one file byte
//   results   source   status, value_offset, value_length        one result
//
// One byte is taken per clock cycle unless the skid entry is full; the parser
// state updates at the byte transfer and any result is registered.
// A result waiting on the results channel does not stop the byte stream: a
// skid entry holds one further result, and bytes stall only when it is full.
// After reset the parse starts at offset 0 as if a first byte had been seen.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module klv_essence_element_locator #(
  parameter int PREFIX_BYTES = 7
) (
  input  wire          clk,
  input  wire          rst,
  klv_byte_if.sink     bytes,
  klv_result_if.source results
);
  import klv_pkg::*;

  logic    accept;
  logic    res_push;
  logic    can_accept;
  result_t res;

  assign bytes.ready = can_accept;
  assign accept      = bytes.valid & can_accept;

  klv_parse #(
    .PREFIX_BYTES (PREFIX_BYTES)
  ) u_parse (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .data_byte  (bytes.data_byte),
    .first_byte (bytes.first_byte),
    .last_byte  (bytes.last_byte),
    .res_push   (res_push),
    .res        (res)
  );

  klv_out_buf u_out_buf (
    .clk        (clk),
    .rst        (rst),
    .push       (res_push),
    .push_data  (res),
    .can_accept (can_accept),
    .results    (results)
  );

endmodule

`default_nettype wire

// File: sim/tb_klv_essence_element_locator.sv
// ----------------------------------------------------------------------------
// KLV essence element locator testbench
// Streams files of KLV triplets through the byte channel and checks each
// found or not-found result against a cycle-free model of the key, length
// and skip walk. Files are mostly well formed, with truncated files and
// noise mixed in, and both channels stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_klv_essence_element_locator;
  import klv_pkg::*;

  localparam int PREFIX_LEN   = 7;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int BYTE_TARGET  = 1250;

  typedef struct {
    logic [7:0] d;
    logic       f;
    logic       l;
  } file_byte_t;

  // Tracks the locator's walk through the stream and holds the results it
  // should produce, oldest first.
  class locator_scoreboard;
    phase_t      phase;
    logic [3:0]  key_idx;
    logic        prefix_ok;
    logic [6:0]  len_left;
    logic [63:0] len_acc;
    logic [63:0] skip_left;
    logic [63:0] position;
    result_t     pending_results[$];
    int          mismatches;
    int          parsed_bytes;

    function new();
      mismatches = 0;
      parsed_bytes = 0;
      restart_walk();
    endfunction

    function void restart_walk();
      phase = PH_KEY;
      key_idx = '0;
      prefix_ok = 1'b1;
      len_left = '0;
      len_acc = '0;
      skip_left = '0;
      position = '0;
    endfunction

    function void push_result(logic st, logic [63:0] off, logic [63:0] len);
      result_t r;
      r.status = st;
      r.value_offset = off;
      r.value_length = len;
      pending_results.push_back(r);
    endfunction

    // The length is complete: either the element is found or its value is
    // skipped and the next key begins.
    function bit length_complete();
      if (prefix_ok) begin
        push_result(STATUS_FOUND, position, len_acc);
        phase = PH_DONE;
        return 1'b1;
      end
      skip_left = len_acc;
      phase = (skip_left == 0) ? PH_KEY : PH_SKIP;
      key_idx = '0;
      prefix_ok = 1'b1;
      return 1'b0;
    endfunction

    function void note_byte(logic [7:0] b, logic first, logic last);
      bit found;
      found = 1'b0;
      if (first) restart_walk();
      if (phase == PH_DONE) return;
      parsed_bytes++;
      position = position + 64'd1;
      case (phase)
        PH_KEY: begin
          if (key_idx < PREFIX_LEN && b != ESSENCE_PREFIX[key_idx]) prefix_ok = 1'b0;
          if (key_idx == 4'd15) begin
            key_idx = '0;
            phase = PH_LEN_FIRST;
          end else begin
            key_idx = key_idx + 4'd1;
          end
        end
        PH_LEN_FIRST: begin
          if (b < 8'h80) begin
            len_acc = {56'd0, b};
            found = length_complete();
          end else begin
            len_acc = '0;
            len_left = b[6:0];
            if (len_left == 0) found = length_complete();
            else phase = PH_LEN_MORE;
          end
        end
        PH_LEN_MORE: begin
          len_acc = {len_acc[55:0], b};
          len_left = len_left - 7'd1;
          if (len_left == 0) found = length_complete();
        end
        PH_SKIP: begin
          skip_left = skip_left - 64'd1;
          if (skip_left == 0) phase = PH_KEY;
        end
        default: begin
          phase = PH_DONE;
          return;
        end
      endcase
      if (!found && last && phase != PH_DONE) begin
        push_result(STATUS_NOT_FOUND, 64'd0, 64'd0);
        phase = PH_DONE;
      end
    endfunction

    function void note_mismatch(string msg);
      mismatches++;
      if (mismatches <= 10) $display("mismatch: %s", msg);
    endfunction

    function void check_result(logic st, logic [63:0] off, logic [63:0] len);
      result_t want;
      if (pending_results.size() == 0) begin
        note_mismatch($sformatf("unexpected result status %0d offset %0h length %0h",
                                st, off, len));
        return;
      end
      want = pending_results.pop_front();
      if (st !== want.status)
        note_mismatch($sformatf("status expected %0d actual %0d", want.status, st));
      if (off !== want.value_offset)
        note_mismatch($sformatf("value_offset expected %0h actual %0h",
                                want.value_offset, off));
      if (len !== want.value_length)
        note_mismatch($sformatf("value_length expected %0h actual %0h",
                                want.value_length, len));
    endfunction

    function int pending();
      return pending_results.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  int   cycle_count;
  int   idle_pct;

  klv_byte_if   bytes_ch ();
  klv_result_if results_ch ();

  klv_essence_element_locator #(
    .PREFIX_BYTES (PREFIX_LEN)
  ) u_top (
    .clk     (clk),
    .rst     (rst),
    .bytes   (bytes_ch),
    .results (results_ch)
  );

  locator_scoreboard sb = new();
  file_byte_t        file_q[$];

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && bytes_ch.valid && bytes_ch.ready)
      sb.note_byte(bytes_ch.data_byte, bytes_ch.first_byte, bytes_ch.last_byte);
  end

  always @(posedge clk) begin
    if (!rst && results_ch.valid && results_ch.ready)
      sb.check_result(results_ch.status, results_ch.value_offset,
                      results_ch.value_length);
  end

  always @(negedge clk) begin
    results_ch.ready = ($urandom_range(0, 99) >= idle_pct);
  end

  function automatic void push_byte(logic [7:0] d);
    file_byte_t it;
    it.d = d;
    it.f = 1'b0;
    it.l = 1'b0;
    file_q.push_back(it);
  endfunction

  // A key either carries the essence prefix or misses it, most often by a
  // single byte within the compared part.
  function automatic void add_key(bit is_match);
    logic [7:0] k [KEY_BYTES];
    int pos;
    for (int i = 0; i < KEY_BYTES; i++) begin
      k[i] = 8'($urandom_range(0, 255));
      if (is_match && i < PREFIX_LEN) k[i] = ESSENCE_PREFIX[i];
    end
    if (!is_match && $urandom_range(0, 9) < 7) begin
      for (int i = 0; i < PREFIX_LEN; i++) k[i] = ESSENCE_PREFIX[i];
      pos = $urandom_range(0, PREFIX_LEN - 1);
      k[pos] = ESSENCE_PREFIX[pos] ^ 8'($urandom_range(1, 255));
    end
    for (int i = 0; i < KEY_BYTES; i++) push_byte(k[i]);
  endfunction

  // Skipped values stay short, but their long-form lengths may carry leading
  // zero bytes, past eight of them at times.
  function automatic void add_skip_length(int len);
    int n;
    if (len < 128 && $urandom_range(0, 2) != 0) begin
      push_byte(8'(len));
    end else begin
      n = (len == 0) ? 0 : ((len < 256) ? 1 : 2);
      n += $urandom_range(0, 9);
      push_byte(8'h80 | 8'(n));
      for (int i = n - 1; i >= 0; i--) push_byte((i < 4) ? 8'(len >> (8 * i)) : 8'h00);
    end
  endfunction

  // The found element's value is never walked, so any length encoding will do.
  function automatic void add_match_length();
    int n;
    int mode;
    mode = $urandom_range(0, 19);
    if (mode < 6) begin
      push_byte(8'($urandom_range(0, 127)));
      return;
    end
    if (mode < 8) n = 0;
    else if (mode < 15) n = $urandom_range(1, 8);
    else if (mode < 19) n = $urandom_range(9, 16);
    else n = 127;
    push_byte(8'h80 | 8'(n));
    repeat (n) push_byte(8'($urandom_range(0, 255)));
  endfunction

  function automatic void add_skipped_element();
    int len;
    len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
    add_key(1'b0);
    add_skip_length(len);
    repeat (len) push_byte(8'($urandom_range(0, 255)));
  endfunction

  function automatic void add_well_formed(bit with_match);
    if (with_match) begin
      repeat ($urandom_range(0, 3)) add_skipped_element();
      add_key(1'b1);
      add_match_length();
      if ($urandom_range(0, 3) != 0)
        repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(1, 3)) add_skipped_element();
    end
  endfunction

  function automatic void build_file();
    int kind;
    int cut;
    kind = $urandom_range(0, 99);
    file_q.delete();
    if (kind < 55) begin
      add_well_formed(1'b1);
    end else if (kind < 75) begin
      add_well_formed(1'b0);
    end else if (kind < 90) begin
      add_well_formed($urandom_range(0, 1));
      cut = $urandom_range(1, file_q.size());
      while (file_q.size() > cut) void'(file_q.pop_back());
    end else begin
      repeat ($urandom_range(1, 40)) push_byte(8'($urandom_range(0, 255)));
    end
    file_q[0].f = 1'b1;
    // Now and then a file ends without its last byte marked, so the next
    // first byte cuts the walk short.
    if ($urandom_range(0, 9) != 0) file_q[file_q.size() - 1].l = 1'b1;
  endfunction

  task automatic send_byte(file_byte_t it);
    while ($urandom_range(0, 99) < idle_pct) begin
      bytes_ch.valid = 1'b0;
      bytes_ch.data_byte = 8'($urandom_range(0, 255));
      bytes_ch.first_byte = 1'($urandom_range(0, 1));
      bytes_ch.last_byte = 1'($urandom_range(0, 1));
      @(negedge clk);
    end
    bytes_ch.valid = 1'b1;
    bytes_ch.data_byte = it.d;
    bytes_ch.first_byte = it.f;
    bytes_ch.last_byte = it.l;
    @(posedge clk);
    while (!bytes_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_file();
    foreach (file_q[i]) send_byte(file_q[i]);
  endtask

  initial begin
    int file_idx;
    cycle_count = 0;
    idle_pct = 38;
    rst = 1'b1;
    bytes_ch.valid = 1'b0;
    bytes_ch.data_byte = 8'h00;
    bytes_ch.first_byte = 1'b0;
    bytes_ch.last_byte = 1'b0;
    results_ch.ready = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Straight after reset, with no first byte: an essence key whose
    // zero-length long form completes on the file's last byte.
    file_q.delete();
    for (int i = 0; i < KEY_BYTES; i++)
      push_byte((i < PREFIX_LEN) ? ESSENCE_PREFIX[i] : ((i % 2) ? 8'h00 : 8'hff));
    push_byte(8'h80);
    file_q[file_q.size() - 1].l = 1'b1;
    // Ignored once done, even with the last-byte flag.
    push_byte(8'h55);
    file_q[file_q.size() - 1].l = 1'b1;
    // A one-byte file ends before any key is complete.
    push_byte(8'hff);
    file_q[file_q.size() - 1].f = 1'b1;
    file_q[file_q.size() - 1].l = 1'b1;
    push_byte(8'h00);
    send_file();

    file_idx = 0;
    while (sb.parsed_bytes < BYTE_TARGET) begin
      idle_pct = (file_idx >= 10 && file_idx < 22) ? 0 : 38;
      build_file();
      send_file();
      file_idx++;
    end
    idle_pct = 38;
    bytes_ch.valid = 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
